// ===== rtl/integer_to_ascii_macros.svh =====
// Assertion helpers for the integer_to_ascii checker.
`ifndef INTEGER_TO_ASCII_MACROS_SVH
`define INTEGER_TO_ASCII_MACROS_SVH

// Clocked on clk_i, off while rst_ni is low.
`define ITOA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("integer_to_ascii check failed");

// Clocked on clk_i, also checked during reset.
`define ITOA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("integer_to_ascii check failed");

`endif

// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned NUM_DIGITS    = 10;
  localparam int unsigned HEX_DIGITS    = 8;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned CONV_STEPS    = WORD_W / BITS_PER_STEP;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned IDX_W         = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                                 hex;
    logic                                 neg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
    logic [IDX_W-1:0]                     ndig;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qwr_t;

endpackage

// ===== rtl/itoa_front.sv =====
module itoa_front import itoa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push,
  output logic   full,
  input  item_t  item_i,
  input  logic   q_full_i,
  output logic   q_push_o,
  output entry_t entry_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  localparam int unsigned CNT_W = $clog2(CONV_STEPS);
  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

  fstate_e           state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic              hex_q, hex_d;
  logic              neg_q, neg_d;
  logic              accept;
  logic              item_neg;

  function automatic logic [BCD_W-1:0] dd_step(logic [BCD_W-1:0] bcd, logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = adj[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  assign full     = (state_q != F_IDLE);
  assign accept   = push && (state_q == F_IDLE);
  assign item_neg = !item_i.cmd && item_i.value[WORD_W-1];
  assign q_push_o = (state_q == F_PUSH);

  always_comb begin
    logic [BCD_W-1:0] b;
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    hex_d   = hex_q;
    neg_d   = neg_q;
    b       = bcd_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          hex_d = item_i.cmd;
          neg_d = item_neg;
          cnt_d = '0;
          if (item_i.cmd) begin
            bcd_d   = {{(BCD_W-WORD_W){1'b0}}, item_i.value};
            state_d = F_PUSH;
          end else begin
            mag_d   = item_neg ? (~item_i.value + WORD_W'(1)) : item_i.value;
            bcd_d   = '0;
            state_d = F_CONV;
          end
        end
      end
      F_CONV: begin
        for (int k = 0; k < BITS_PER_STEP; k++) begin
          b = dd_step(b, mag_q[WORD_W-1-k]);
        end
        bcd_d = b;
        mag_d = mag_q << BITS_PER_STEP;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    entry_o.hex    = hex_q;
    entry_o.neg    = neg_q;
    entry_o.digits = bcd_q;
    entry_o.ndig   = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0) begin
        entry_o.ndig = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    hex_q <= hex_d;
    neg_q <= neg_d;
  end

endmodule

// ===== rtl/itoa_queue.sv =====
module itoa_queue import itoa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  input  entry_t wr_data_i,
  output qwr_t   wr_stat_o,
  input  logic   rd_pop_i,
  output logic   rd_empty_o,
  output entry_t rd_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign wr_stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign wr_stat_o.valid = wr_valid_i;
  assign rd_empty_o      = (cnt_q == '0);
  assign rd_data_o       = mem_q[rd_ptr_q];
  assign do_wr           = wr_valid_i && !wr_stat_o.full;
  assign do_rd           = rd_pop_i && !rd_empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/itoa_back.sv =====
module itoa_back import itoa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  entry_t  q_data_i,
  output logic    q_pop_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic                               busy_q, busy_d;
  logic                               sign_q, sign_d;
  logic                               hex_q;
  logic [IDX_W-1:0]                   idx_q, idx_d;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
  logic                               out_valid_q, out_valid_d;
  result_t                            out_q;
  logic                               load, advance, last_char;
  logic [DIGIT_W-1:0]                 cur_digit;
  logic [7:0]                         cur_char;

  assign load      = !busy_q && !q_empty_i;
  assign q_pop_o   = load;
  assign advance   = busy_q && (!out_valid_q || pop);
  assign cur_digit = digits_q[idx_q];
  assign last_char = !sign_q && (idx_q == '0);

  always_comb begin
    if (sign_q) begin
      cur_char = CHAR_MINUS;
    end else if (hex_q && (cur_digit >= DEC_BASE)) begin
      cur_char = CHAR_A + 8'({4'b0, cur_digit - DEC_BASE});
    end else begin
      cur_char = CHAR_ZERO + 8'({4'b0, cur_digit});
    end
  end

  always_comb begin
    busy_d      = busy_q;
    sign_d      = sign_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      sign_d = q_data_i.neg;
      idx_d  = q_data_i.ndig;
    end else if (advance) begin
      out_valid_d = 1'b1;
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      sign_q      <= sign_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hex_q    <= q_data_i.hex;
      digits_q <= q_data_i.digits;
    end
    if (advance) begin
      out_q.char_code <= cur_char;
      out_q.last      <= last_char;
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== rtl/integer_to_ascii.sv =====
// Converts a 32-bit word to ASCII text, one character per result transfer, most
// significant first, with last set on the final character. cmd = 0 reads the word
// as signed and gives decimal with a leading '-' when negative; cmd = 1 gives
// unsigned uppercase hexadecimal. Leading zeros are dropped and zero gives "0".
// The front takes a decimal item through an accept step, shift-and-add-3 BCD
// conversion at four bits per cycle and a hand-off of the digits to a two-entry
// queue, held while the queue is full; a hexadecimal item goes straight from
// accept to hand-off. The front takes no new item until the last is handed off.
// The back drains the queue at one character per cycle while pop is held high,
// plus a load step per entry. Sustained throughput is the slower of the two sides.
module integer_to_ascii import itoa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  entry_t f_entry, q_entry;
  logic   f_push, q_empty, q_pop;
  qwr_t   q_stat;

  itoa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_full_i (q_stat.full),
    .q_push_o (f_push),
    .entry_o  (f_entry)
  );

  itoa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_push),
    .wr_data_i  (f_entry),
    .wr_stat_o  (q_stat),
    .rd_pop_i   (q_pop),
    .rd_empty_o (q_empty),
    .rd_data_o  (q_entry)
  );

  itoa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_entry),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

// ===== rtl/itoa_checker.sv =====
`include "integer_to_ascii_macros.svh"

module itoa_checker import itoa_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    push,
  input logic    full,
  input item_t   item_i,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  logic item_seen;

  assign item_seen = (item_i.cmd == 1'b0) || (item_i.cmd == 1'b1);

  `ITOA_ASSERT(a_hold_result, (!empty && !pop) |=> (!empty && $stable(result_o)))
  `ITOA_ASSERT(a_busy_after_transfer, (push && !full && item_seen) |=> full)
  `ITOA_ASSERT(a_minus_not_last, (!empty && result_o.char_code == CHAR_MINUS) |-> !result_o.last)
  `ITOA_ASSERT(a_char_set, !empty |-> ((result_o.char_code >= CHAR_ZERO && result_o.char_code <= 8'h39) || (result_o.char_code >= CHAR_A && result_o.char_code <= 8'h46) || result_o.char_code == CHAR_MINUS))

endmodule

bind integer_to_ascii itoa_checker u_itoa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== tb/sv/tb.sv =====
module tb;
  import itoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;
  localparam int RANDOM_WORDS = 238;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic              cmd;
    logic [WORD_W-1:0] value;
    string             text;
  } known_row_t;

  known_row_t known_words [22] = '{
    '{MODE_DEC, 32'h0000_0000, "0"},
    '{MODE_HEX, 32'h0000_0000, "0"},
    '{MODE_DEC, 32'h8000_0000, "-2147483648"},
    '{MODE_DEC, 32'h7FFF_FFFF, "2147483647"},
    '{MODE_DEC, 32'hFFFF_FFFF, "-1"},
    '{MODE_DEC, 32'h8000_0001, "-2147483647"},
    '{MODE_DEC, 32'hFFFF_FFF6, "-10"},
    '{MODE_DEC, 32'd9, "9"},
    '{MODE_DEC, 32'd10, "10"},
    '{MODE_DEC, 32'd999999999, "999999999"},
    '{MODE_DEC, 32'd1000000000, "1000000000"},
    '{MODE_HEX, 32'hFFFF_FFFF, "FFFFFFFF"},
    '{MODE_HEX, 32'h8000_0000, "80000000"},
    '{MODE_HEX, 32'h0000_0009, "9"},
    '{MODE_HEX, 32'h0000_000A, "A"},
    '{MODE_HEX, 32'h0000_000F, "F"},
    '{MODE_HEX, 32'h0000_0010, "10"},
    '{MODE_HEX, 32'h0123_ABCD, "123ABCD"},
    '{MODE_DEC, 32'hDEAD_BEEF, ""},
    '{MODE_HEX, 32'h5A5A_5A5A, ""},
    '{MODE_DEC, 32'd12345, ""},
    '{MODE_HEX, 32'h7FFF_FFFF, ""}
  };

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  item_t   item_i;
  logic    empty;
  logic    pop;
  result_t result_o;

  result_t pending_chars[$];
  int      faults;
  int      chars_taken;
  int      cycle_count;
  bit      send_busy;
  bit      take_busy;

  integer_to_ascii dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void queue_text(input string text);
    result_t r;
    for (int i = 0; i < text.len(); i++) begin
      r.char_code = text[i];
      r.last = (i == text.len() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  // Decimal reads the word as two's complement; hex reads it as unsigned.
  function automatic void spell_word(input logic cmd, input logic [WORD_W-1:0] word);
    logic [7:0]        digits[$];
    logic [WORD_W-1:0] mag;
    logic [3:0]        nib;
    logic              neg;
    result_t           r;
    neg = 1'b0;
    if (cmd == MODE_DEC) begin
      neg = word[WORD_W-1];
      mag = neg ? ~word + 32'd1 : word;
      do begin
        digits.push_front(CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) digits.push_front(CHAR_MINUS);
    end else begin
      mag = word;
      do begin
        nib = mag[3:0];
        digits.push_front(nib < 4'd10 ? CHAR_ZERO + 8'(nib) : CHAR_A + 8'(nib - 4'd10));
        mag = mag >> 4;
      end while (mag != 0);
    end
    for (int i = 0; i < digits.size(); i++) begin
      r.char_code = digits[i];
      r.last = (i == digits.size() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] p;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = $urandom >> $urandom_range(0, 31);
      2: w = ~($urandom >> $urandom_range(0, 31)) + 32'd1;
      3: w = $urandom_range(0, 20);
      4: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        w = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) w = ~w + 32'd1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: w = 32'h8000_0000;
          1: w = 32'h7FFF_FFFF;
          2: w = 32'hFFFF_FFFF;
          default: w = 32'h0000_0000;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic offer_word(input logic cmd, input logic [WORD_W-1:0] word,
                            input string text);
    int gap;
    gap = send_busy ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= '{cmd: cmd, value: word};
    do @(posedge clk_i); while (full);
    if (text.len() > 0) queue_text(text);
    else spell_word(cmd, word);
  endtask

  task automatic drain_pending();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  task automatic check_char(input result_t got);
    result_t want;
    if (pending_chars.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected transfer: char %h last %b", got.char_code, got.last);
    end else begin
      want = pending_chars.pop_front();
      if (got.char_code !== want.char_code || got.last !== want.last) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected char %h last %b, got char %h last %b",
                   want.char_code, want.last, got.char_code, got.last);
      end
    end
  endtask

  initial begin
    int gap;
    pop = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (chars_taken % 25 == 0) take_busy = $urandom_range(0, 2) != 0;
      gap = take_busy ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_char(result_o);
      chars_taken++;
      // hold off so the block fills and stalls its input
      if (chars_taken == HOLD_AFTER) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic cmd;
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    faults = 0;
    chars_taken = 0;
    cycle_count = 0;
    send_busy = 1'b1;
    take_busy = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (known_words[i])
      offer_word(known_words[i].cmd, known_words[i].value, known_words[i].text);
    drain_pending();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 30 == 0) send_busy = $urandom_range(0, 2) != 0;
      if (n == RANDOM_WORDS / 2) drain_pending();
      cmd = $urandom_range(0, 1) ? MODE_HEX : MODE_DEC;
      offer_word(cmd, draw_word(), "");
    end
    drain_pending();
    repeat (40) @(posedge clk_i);

    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_front.sv
rtl/itoa_queue.sv
rtl/itoa_back.sv
rtl/integer_to_ascii.sv
rtl/itoa_checker.sv
tb/sv/tb.sv
